// ===== hw/rtl/ifla_pkg.sv =====
`timescale 1ns / 1ps

package ifla_pkg;

  // Fixed field widths of the ports
  localparam int KIND_W = 2;
  localparam int IDX_FW = 10;
  localparam int STAT_W = 2;
  localparam int CNT_FW = 11;
  localparam int SIZE_W = 11;

  // Default storage depth and pool_size value after reset
  localparam int POOL_DEPTH_DEF = 1024;
  localparam int POOL_SIZE_RST  = 1024;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REWIND  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREE  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic issue;        // latch request, read queue head and flag
    logic sweep_start;  // latch new size, reset head and count
    logic sweep_step;   // write one queue entry and clear one flag
    logic commit;       // apply the request and load the result
  } ifla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;   // sweep counter is on the last entry of the pool
    logic slot_free;    // result register can take a new word
  } ifla_stat_t;

endpackage

// ===== hw/rtl/index_free_list_allocator.sv =====
`timescale 1ns / 1ps

// Free-list index allocator. Each request word (allocate, release or rewind)
// yields exactly one result word. Allocate, release and the unused kind first
// take a registered read of the queue and flag memories, then write back and
// load the result register; the result register lets the next request enter
// while a result waits. A rewind takes the request, then runs a sweep over
// S entries, S being the clamped pool_size, which writes one queue entry and
// clears one flag per cycle, and then loads the result. After reset an
// initial sweep over min(1024, POOL_DEPTH) entries runs with in_ready low;
// pool_size writes are taken at any time and apply at the next rewind.

module index_free_list_allocator import ifla_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] pool_size,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [IDX_FW-1:0] release_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_FW-1:0] granted_index,
  output logic [STAT_W-1:0] status,
  output logic [CNT_FW-1:0] free_count
);

  ifla_cmd_t  cmd;
  ifla_stat_t stat;

  assign cfg_ready = 1'b1;

  ifla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ifla_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .pool_size     (pool_size),
    .kind          (kind),
    .release_index (release_index),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_index (granted_index),
    .status        (status),
    .free_count    (free_count)
  );

  // A result is only loaded when the result register can take it
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.slot_free)
    else $error("result loaded over an untaken result");

  // At most one datapath action per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.issue, cmd.sweep_start, cmd.sweep_step, cmd.commit}))
    else $error("conflicting datapath commands");

  // Empty pool is reported with a zero free count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (free_count == '0))
    else $error("empty status with free entries");

  // Only a successful allocate hands out a nonzero index
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_index == '0))
    else $error("index granted on a failed request");

endmodule

// ===== hw/rtl/ifla_ctrl.sv =====
`timescale 1ns / 1ps

module ifla_ctrl import ifla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] kind,
  input  ifla_stat_t        stat,
  output logic              in_ready,
  output ifla_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_REWIND) begin
            cmd.sweep_start = 1'b1;
            state_next      = S_SWEEP;
          end else begin
            cmd.issue  = 1'b1;
            state_next = S_EXEC;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/ifla_dp.sv =====
`timescale 1ns / 1ps

module ifla_dp import ifla_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] pool_size,
  input  logic [KIND_W-1:0] kind,
  input  logic [IDX_FW-1:0] release_index,
  input  ifla_cmd_t         cmd,
  output ifla_stat_t        stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_FW-1:0] granted_index,
  output logic [STAT_W-1:0] status,
  output logic [CNT_FW-1:0] free_count
);

  localparam int IDX_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
  localparam int SZ_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int RI_W     = (CNT_W > IDX_FW) ? CNT_W : IDX_FW;
  localparam int RST_SIZE = (POOL_SIZE_RST > POOL_DEPTH) ? POOL_DEPTH : POOL_SIZE_RST;

  // Control registers
  logic [SIZE_W-1:0] pool_size_r;
  logic [CNT_W-1:0]  active_size;
  logic [CNT_W-1:0]  free_total;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  sweep_cnt;

  // Latched request
  logic [KIND_W-1:0] kind_r;
  logic [IDX_FW-1:0] idx_r;
  logic [IDX_W-1:0]  tail;

  // Queue and flag memories with registered reads
  logic [IDX_W-1:0] queue_mem [POOL_DEPTH];
  logic             flag_mem  [POOL_DEPTH];
  logic [IDX_W-1:0] q_rd;
  logic             flag_rd;

  logic             q_we;
  logic [IDX_W-1:0] q_wa;
  logic [IDX_W-1:0] q_wd;
  logic             f_we;
  logic [IDX_W-1:0] f_wa;
  logic             f_wd;

  logic [CNT_W-1:0]  size_clamped;
  logic [CNT_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_next;
  logic [CNT_W-1:0]  head_inc;
  logic              in_range;
  logic              alloc_ok;
  logic              rel_ok;
  logic [CNT_W-1:0]  free_total_next;
  logic [STAT_W-1:0] res_status;

  // Requested size forced into 1..POOL_DEPTH
  always_comb begin
    if (pool_size_r == '0) begin
      size_clamped = CNT_W'(1);
    end else if (SZ_W'(pool_size_r) > SZ_W'(POOL_DEPTH)) begin
      size_clamped = CNT_W'(POOL_DEPTH);
    end else begin
      size_clamped = CNT_W'(pool_size_r);
    end
  end

  // Tail slot, wrapped once inside the active pool
  always_comb begin
    tail_sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(free_total);
    if (tail_sum >= (CNT_W + 1)'(active_size)) begin
      tail_next = IDX_W'(tail_sum - (CNT_W + 1)'(active_size));
    end else begin
      tail_next = IDX_W'(tail_sum);
    end
  end

  // Request outcome
  assign head_inc = CNT_W'(head) + CNT_W'(1);
  assign in_range = RI_W'(idx_r) < RI_W'(active_size);
  assign alloc_ok = (kind_r == KIND_ALLOC) && (free_total != '0);
  assign rel_ok   = (kind_r == KIND_RELEASE) && in_range && flag_rd &&
                    (free_total < active_size);

  always_comb begin
    free_total_next = free_total;
    res_status      = ST_OK;
    if (kind_r == KIND_ALLOC) begin
      if (alloc_ok) begin
        free_total_next = free_total - CNT_W'(1);
      end else begin
        res_status = ST_EMPTY;
      end
    end else if (kind_r == KIND_RELEASE) begin
      priority if (!in_range) begin
        res_status = ST_RANGE;
      end else if (!rel_ok) begin
        res_status = ST_FREE;
      end else begin
        free_total_next = free_total + CNT_W'(1);
      end
    end
  end

  // Memory write ports
  always_comb begin
    q_we = 1'b0;
    q_wa = sweep_cnt;
    q_wd = sweep_cnt;
    f_we = 1'b0;
    f_wa = sweep_cnt;
    f_wd = 1'b0;
    if (cmd.sweep_step) begin
      q_we = 1'b1;
      f_we = 1'b1;
    end else if (cmd.commit && alloc_ok) begin
      f_we = 1'b1;
      f_wa = q_rd;
      f_wd = 1'b1;
    end else if (cmd.commit && rel_ok) begin
      q_we = 1'b1;
      q_wa = tail;
      q_wd = IDX_W'(idx_r);
      f_we = 1'b1;
      f_wa = IDX_W'(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    if (cmd.issue) begin
      q_rd <= queue_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      flag_mem[f_wa] <= f_wd;
    end
    if (cmd.issue) begin
      flag_rd <= flag_mem[IDX_W'(release_index)];
    end
  end

  // Pool state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size_r <= SIZE_W'(POOL_SIZE_RST);
      active_size <= CNT_W'(RST_SIZE);
      free_total  <= CNT_W'(RST_SIZE);
      head        <= '0;
      sweep_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pool_size_r <= pool_size;
      end
      if (cmd.sweep_start) begin
        active_size <= size_clamped;
        free_total  <= size_clamped;
        head        <= '0;
        sweep_cnt   <= '0;
      end
      if (cmd.sweep_step) begin
        sweep_cnt <= sweep_cnt + IDX_W'(1);
      end
      if (cmd.commit) begin
        free_total <= free_total_next;
        if (alloc_ok) begin
          head <= (head_inc >= active_size) ? '0 : IDX_W'(head_inc);
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.issue || cmd.sweep_start) begin
      kind_r <= kind;
    end
    if (cmd.issue) begin
      idx_r <= release_index;
      tail  <= tail_next;
    end
    if (cmd.commit) begin
      granted_index <= alloc_ok ? IDX_FW'(q_rd) : '0;
      status        <= res_status;
      free_count    <= CNT_FW'(free_total_next);
    end
  end

  assign stat.sweep_last = (sweep_cnt == IDX_W'(active_size - CNT_W'(1)));
  assign stat.slot_free  = !out_valid || out_ready;

endmodule
